[sv/qbsd_pkg.sv]
// Shared types and constants for the Q8 block-scaled dot product.
package qbsd_pkg;

    localparam int ACT_FRAC_BITS_DEF = 16;
    localparam int MAX_ROWS_DEF      = 4096;
    localparam int QUEUE_DEPTH       = 4;

    localparam int W_WEIGHT = 8;
    localparam int W_SCALE  = 16;
    localparam int W_ACT    = 32;
    localparam int W_WS     = 19;   // weight * signed mantissa, |x| <= 128 * 2047
    localparam int W_EXP    = 5;
    localparam int W_SUM    = 48;
    localparam int W_IDX    = 12;

    localparam int W_S_TDATA = 56;  // 8 + 16 + 32, already whole bytes
    localparam int W_M_TDATA = 64;  // 48 + 12, padded to 8 bytes

    // Half-float field codes
    localparam logic [W_EXP-1:0] EXP_ZERO = 5'h00;
    localparam logic [W_EXP-1:0] EXP_ONES = 5'h1F;
    localparam logic [W_EXP-1:0] EXP_SAT  = 5'd30;
    localparam logic [W_EXP-1:0] EXP_SUB  = 5'd1;
    localparam logic [11:0]      MANT_SAT = 12'd2047;

    // One classified element travelling from front to back
    typedef struct packed {
        logic [W_WS-1:0]  ws;          // signed weight * mantissa
        logic [W_EXP-1:0] expo;        // effective exponent, 1..30
        logic [W_ACT-1:0] act;         // signed activation
        logic             last_in_row;
        logic             last_row;
    } t_qentry;

endpackage

[sv/q8_block_scaled_dot_product.sv]
// Top level of the Q8 block-scaled dot product engine.
// Usage:
//   Slave channel: one transaction per weight element. tdata carries the int8
//   weight, the raw half-float block scale and the signed activation; tlast
//   marks the last element of a row, tuser marks the last row of the matrix.
//   Master channel: one transaction per row with the saturated Q31.16 row sum
//   and the row index in tdata, and the clip flag in tuser.
// Dataflow:
//   The front end decodes the scale and forms weight * mantissa in the accept
//   cycle and pushes the element into a 4-entry queue. The back end runs each
//   element through the pop, multiply, shift/round and accumulate states in
//   turn, one element at a time, as set by the serial multiply/shift/accumulate
//   sequence of the back end. A row result is registered into the output
//   register when the last element of its row is accumulated.
// Reset (synchronous, active low) clears the accumulator, clip flag, row
//   counter, queue and output valid.
// Stall: while the master side holds tready low, the finished row waits in the
//   output register; the back end keeps accumulating the next row and only
//   blocks at that row's end. The queue then fills and tready drops.
module q8_block_scaled_dot_product #(
    parameter int ACT_FRAC_BITS = qbsd_pkg::ACT_FRAC_BITS_DEF,
    parameter int MAX_ROWS      = qbsd_pkg::MAX_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [7:0] weight, [23:8] scale_bits, [55:24] activation
    input  logic [qbsd_pkg::W_S_TDATA-1:0]  i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,   // last_in_row
    input  logic                            i_s_axis_tuser,   // [0] last_row
    // master side
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [47:0] row_sum, [59:48] row_index, [63:60] zero
    output logic [qbsd_pkg::W_M_TDATA-1:0]  o_m_axis_tdata,
    output logic                            o_m_axis_tuser    // [0] saturated
);

    logic              q_full;
    logic              q_push;
    logic              q_empty;
    logic              q_pop;
    qbsd_pkg::t_qentry q_in;
    qbsd_pkg::t_qentry q_out;

    qbsd_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_entry       (q_in)
    );

    qbsd_fifo #(
        .DEPTH (qbsd_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_entry (q_out)
    );

    qbsd_back #(
        .ACT_FRAC_BITS (ACT_FRAC_BITS),
        .MAX_ROWS      (MAX_ROWS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_entry       (q_out),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

[sv/qbsd_front.sv]
// Front end: takes input transactions, decodes the half-float scale, forms weight * mantissa.
module qbsd_front (
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [qbsd_pkg::W_S_TDATA-1:0]    i_s_axis_tdata,
    input  logic                              i_s_axis_tlast,
    input  logic                              i_s_axis_tuser,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output qbsd_pkg::t_qentry                 o_q_entry
);

    logic signed [qbsd_pkg::W_WEIGHT-1:0] weight;
    logic [qbsd_pkg::W_SCALE-1:0]         scale_bits;
    logic [qbsd_pkg::W_EXP-1:0]           ex;
    logic [9:0]                           frac;
    logic [11:0]                          mag;
    logic signed [11:0]                   sm;
    logic [qbsd_pkg::W_EXP-1:0]           expo;
    logic signed [qbsd_pkg::W_WS-1:0]     ws;

    assign weight     = $signed(i_s_axis_tdata[7:0]);
    assign scale_bits = i_s_axis_tdata[23:8];
    assign ex         = scale_bits[14:10];
    assign frac       = scale_bits[9:0];

    always_comb begin
        unique case (ex)
            qbsd_pkg::EXP_ZERO: begin
                mag  = {2'b00, frac};
                expo = qbsd_pkg::EXP_SUB;
            end
            qbsd_pkg::EXP_ONES: begin
                // no infinities: clamp to the largest finite magnitude
                mag  = qbsd_pkg::MANT_SAT;
                expo = qbsd_pkg::EXP_SAT;
            end
            default: begin
                mag  = {2'b01, frac};
                expo = ex;
            end
        endcase
        sm = scale_bits[15] ? -$signed(mag) : $signed(mag);
    end

    assign ws = $signed(weight) * sm;

    assign o_s_axis_tready = ~i_q_full;
    assign o_q_push        = i_s_axis_tvalid & ~i_q_full;

    assign o_q_entry.ws          = ws;
    assign o_q_entry.expo        = expo;
    assign o_q_entry.act         = i_s_axis_tdata[55:24];
    assign o_q_entry.last_in_row = i_s_axis_tlast;
    assign o_q_entry.last_row    = i_s_axis_tuser;

endmodule

[sv/qbsd_fifo.sv]
// Short register queue between the front and back ends.
module qbsd_fifo #(
    parameter int DEPTH = qbsd_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  qbsd_pkg::t_qentry i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output qbsd_pkg::t_qentry o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qbsd_pkg::t_qentry r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

[sv/qbsd_back.sv]
// Back end: multiply by activation, shift and round to Q31.16, saturating accumulate, row output.
module qbsd_back #(
    parameter int ACT_FRAC_BITS = qbsd_pkg::ACT_FRAC_BITS_DEF,
    parameter int MAX_ROWS      = qbsd_pkg::MAX_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    input  qbsd_pkg::t_qentry               i_q_entry,
    output logic                            o_q_pop,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [qbsd_pkg::W_M_TDATA-1:0]  o_m_axis_tdata,
    output logic                            o_m_axis_tuser
);

    localparam int CNT_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int W_P   = qbsd_pkg::W_WS + qbsd_pkg::W_ACT;   // 51
    localparam int W_T   = 64;
    localparam logic [6:0] SH_BIAS = 7'(9 + ACT_FRAC_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_SHF  = 2'd2;
    localparam logic [1:0] S_ACC  = 2'd3;

    logic [1:0]                       r_state, n_state;
    qbsd_pkg::t_qentry                r_ent;
    logic signed [W_P-1:0]            r_prod;
    logic signed [W_T-1:0]            r_term;
    logic signed [qbsd_pkg::W_SUM-1:0] r_acc;
    logic                             r_clip;
    logic [CNT_W-1:0]                 r_row;
    logic                             r_out_valid;
    logic [qbsd_pkg::W_SUM-1:0]       r_out_sum;
    logic [qbsd_pkg::W_IDX-1:0]       r_out_idx;
    logic                             r_out_sat;

    logic [6:0]                       e7;
    logic                             shl;
    logic [5:0]                       shamt;
    logic signed [W_T-1:0]            p_ext;
    logic signed [W_P:0]              p_rnd;
    logic signed [W_P:0]              half_lsb;
    logic signed [W_T-1:0]            term;
    logic signed [W_T:0]              sum;
    logic                             ovf;
    logic signed [qbsd_pkg::W_SUM-1:0] clamped;
    logic                             out_free;
    logic                             fin;
    logic [CNT_W+qbsd_pkg::W_IDX-1:0] row_ext;

    // shift/round of the exact product
    always_comb begin
        e7       = {2'b00, r_ent.expo};
        shl      = (e7 >= SH_BIAS);
        shamt    = shl ? 6'(e7 - SH_BIAS) : 6'(SH_BIAS - e7);
        p_ext    = {{(W_T - W_P){r_prod[W_P-1]}}, r_prod};
        half_lsb = (shamt == '0) ? '0 : ((W_P+1)'(1) <<< (shamt - 6'd1));
        p_rnd    = {r_prod[W_P-1], r_prod} + half_lsb;
        if (shl) begin
            term = p_ext <<< shamt;
        end else begin
            term = {{(W_T - W_P - 1){p_rnd[W_P]}}, (p_rnd >>> shamt)};
        end
    end

    // saturating add into the 48-bit accumulator
    always_comb begin
        sum = {{(W_T + 1 - qbsd_pkg::W_SUM){r_acc[qbsd_pkg::W_SUM-1]}}, r_acc}
            + {r_term[W_T-1], r_term};
        ovf = (sum[W_T:qbsd_pkg::W_SUM-1] != '0) && (sum[W_T:qbsd_pkg::W_SUM-1] != '1);
        if (!ovf) begin
            clamped = sum[qbsd_pkg::W_SUM-1:0];
        end else if (sum[W_T]) begin
            clamped = {1'b1, {(qbsd_pkg::W_SUM-1){1'b0}}};
        end else begin
            clamped = {1'b0, {(qbsd_pkg::W_SUM-1){1'b1}}};
        end
    end

    assign out_free = ~r_out_valid | i_m_axis_tready;
    assign fin      = (r_state == S_ACC) && (~r_ent.last_in_row || out_free);
    assign o_q_pop  = (r_state == S_IDLE) && ~i_q_empty;
    assign row_ext  = {{qbsd_pkg::W_IDX{1'b0}}, r_row};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_q_empty) n_state = S_MUL;
            S_MUL:   n_state = S_SHF;
            S_SHF:   n_state = S_ACC;
            S_ACC:   if (fin) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_clip      <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin && r_ent.last_in_row) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (fin) begin
                if (r_ent.last_in_row) begin
                    r_acc       <= '0;
                    r_clip      <= 1'b0;
                    if (r_ent.last_row || (r_row >= CNT_W'(MAX_ROWS - 1))) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_acc  <= clamped;
                    r_clip <= r_clip | ovf;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ent <= i_q_entry;
        end
        if (r_state == S_MUL) begin
            r_prod <= $signed(r_ent.ws) * $signed(r_ent.act);
        end
        if (r_state == S_SHF) begin
            r_term <= term;
        end
        if (fin && r_ent.last_in_row) begin
            r_out_sum <= clamped;
            r_out_idx <= row_ext[qbsd_pkg::W_IDX-1:0];
            r_out_sat <= r_clip | ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_idx, r_out_sum};
    assign o_m_axis_tuser  = r_out_sat;

endmodule
